// ===== hw/rtl/ptab_pkg.sv =====
// Shared types, codes and constants of the two-level page table engine.
`timescale 1ns / 1ps

package ptab_pkg;

  localparam int unsigned DIR_ENTRIES       = 1024;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned IDX_W             = 10;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam int unsigned ENT_W             = 23;

  // Entry layout: [22:3] frame, [2] user, [1] writable, [0] present
  localparam logic [ENT_W-1:0] ENT_KEEP_MASK = 23'h000006;

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_XLATE = 2'd2;

  localparam logic [1:0] STS_DONE       = 2'd0;
  localparam logic [1:0] STS_NO_TABLE   = 2'd1;
  localparam logic [1:0] STS_POOL_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic        flag_present;
    logic        flag_writable;
    logic        flag_user;
  } in_word_t;

  typedef struct packed {
    logic [31:0] phys_out;
    logic        present;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIR_RD,
    ST_DECIDE,
    ST_CLEAR,
    ST_MAP_WR,
    ST_PT_RD,
    ST_PT_EVAL,
    ST_RESULT
  } state_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_DONE,
    RES_NO_TABLE,
    RES_POOL_EMPTY,
    RES_XLATE
  } res_op_e;

  typedef struct packed {
    logic    capture;
    logic    dir_rd;
    logic    dir_clr;
    logic    dir_alloc;
    logic    slot_ld;
    logic    pt_clr;
    logic    pt_map_wr;
    logic    pt_rd;
    logic    pt_unmap_wr;
    logic    cnt_inc;
    res_op_e res_op;
    logic    push;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       dir_hit;
    logic       pool_empty;
    logic       cnt_last;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/two_level_page_table_engine_core.sv =====
// Top level of the two-level page table engine: sequencer plus datapath.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+--------------------------------
//   in      | in_valid_i, in_stall_o, in_word_i   | one map/unmap/translate word
//   out     | out_valid_o, out_stall_i, out_word_o| one result word per input word
//
// One word is worked at a time. After accept the directory is read; a map to an
// existing table then writes the entry, unmap/translate read and check the entry,
// a miss or no-op goes to the result; a new table is first cleared through the
// single entry memory port. A sweep after reset clears the directory; input stalls.
// A finished result waits in the output register, so a new word is taken while
// out_stall_i holds the previous one; the next result waits for that register.
`timescale 1ns / 1ps

module two_level_page_table_engine_core #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptab_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptab_pkg::out_word_t out_word_o
);
  import ptab_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ptab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptab_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/ptab_ctrl.sv =====
// Sequencer of the page table engine: init sweep, lookup, table clear, entry update.
`timescale 1ns / 1ps

module ptab_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptab_pkg::dp_sts_t sts_i,
  output ptab_pkg::dp_cmd_t cmd_o
);
  import ptab_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_op = RES_HOLD;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_INIT: begin
        // directory valid bits are swept to zero after reset
        cmd_o.dir_clr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DIR_RD;
        end
      end
      ST_DIR_RD: begin
        cmd_o.dir_rd = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (sts_i.action)
          ACT_MAP: begin
            if (sts_i.dir_hit) begin
              cmd_o.slot_ld = 1'b1;
              state_d = ST_MAP_WR;
            end else if (sts_i.pool_empty) begin
              cmd_o.res_op = RES_POOL_EMPTY;
              state_d = ST_RESULT;
            end else begin
              cmd_o.dir_alloc = 1'b1;
              state_d = ST_CLEAR;
            end
          end
          ACT_UNMAP, ACT_XLATE: begin
            if (sts_i.dir_hit) begin
              cmd_o.slot_ld = 1'b1;
              state_d = ST_PT_RD;
            end else begin
              cmd_o.res_op = RES_NO_TABLE;
              state_d = ST_RESULT;
            end
          end
          default: begin
            cmd_o.res_op = RES_DONE;
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd_o.pt_clr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = ST_MAP_WR;
      end
      ST_MAP_WR: begin
        cmd_o.pt_map_wr = 1'b1;
        cmd_o.res_op    = RES_DONE;
        state_d = ST_RESULT;
      end
      ST_PT_RD: begin
        cmd_o.pt_rd = 1'b1;
        state_d = ST_PT_EVAL;
      end
      ST_PT_EVAL: begin
        if (sts_i.action == ACT_UNMAP) begin
          cmd_o.pt_unmap_wr = 1'b1;
          cmd_o.res_op      = RES_DONE;
        end else begin
          cmd_o.res_op = RES_XLATE;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ptab_dpath.sv =====
// Datapath of the page table engine: directory and entry memories, pool, output register.
`timescale 1ns / 1ps

module ptab_dpath #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptab_pkg::in_word_t  in_word_i,
  input  ptab_pkg::dp_cmd_t   cmd_i,
  output ptab_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptab_pkg::out_word_t out_word_o
);
  import ptab_pkg::*;

  localparam int unsigned SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NF_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned PT_AW    = SLOT_W + IDX_W;
  localparam int unsigned PT_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int unsigned DIR_W    = SLOT_W + 1;

  in_word_t              item_q;
  logic [IDX_W-1:0]      cnt_q;
  logic [NF_W-1:0]       nf_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [DIR_W-1:0]      dir_rd_q;
  logic [ENT_W-1:0]      pt_rd_q;
  out_word_t             res_q, res_d;
  out_word_t             out_q;
  logic                  out_valid_q;

  logic [DIR_W-1:0]      dir_mem [DIR_ENTRIES];
  logic [ENT_W-1:0]      pt_mem  [PT_DEPTH];

  logic [IDX_W-1:0]      di, ti;
  logic [IDX_W-1:0]      dir_addr;
  logic [DIR_W-1:0]      dir_wdata;
  logic                  dir_we;
  logic [PT_AW-1:0]      pt_addr;
  logic [ENT_W-1:0]      pt_wdata;
  logic                  pt_we;
  logic [ENT_W-1:0]      new_entry;

  assign di = item_q.vaddr[31:22];
  assign ti = item_q.vaddr[21:12];

  assign new_entry = {item_q.paddr[31:PAGE_SHIFT], item_q.flag_user,
                      item_q.flag_writable, item_q.flag_present};

  // directory port: init sweep, allocation write, lookup read
  assign dir_addr  = cmd_i.dir_clr ? cnt_q : di;
  assign dir_wdata = cmd_i.dir_clr ? '0 : {1'b1, nf_q[SLOT_W-1:0]};
  assign dir_we    = cmd_i.dir_clr | cmd_i.dir_alloc;

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_addr] <= dir_wdata;
    end else if (cmd_i.dir_rd) begin
      dir_rd_q <= dir_mem[dir_addr];
    end
  end

  // entry port: table clear sweep, map write, unmap write-back, lookup read
  assign pt_addr = cmd_i.pt_clr ? {slot_q, cnt_q} : {slot_q, ti};
  assign pt_we   = cmd_i.pt_clr | cmd_i.pt_map_wr | cmd_i.pt_unmap_wr;

  always_comb begin
    if (cmd_i.pt_clr) begin
      pt_wdata = '0;
    end else if (cmd_i.pt_map_wr) begin
      pt_wdata = new_entry;
    end else begin
      pt_wdata = pt_rd_q & ENT_KEEP_MASK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_addr] <= pt_wdata;
    end else if (cmd_i.pt_rd) begin
      pt_rd_q <= pt_mem[pt_addr];
    end
  end

  always_comb begin
    res_d = res_q;
    case (cmd_i.res_op)
      RES_HOLD: res_d = res_q;
      RES_DONE: res_d = '0;
      RES_NO_TABLE: begin
        res_d = '0;
        res_d.status = STS_NO_TABLE;
      end
      RES_POOL_EMPTY: begin
        res_d = '0;
        res_d.status = STS_POOL_EMPTY;
      end
      RES_XLATE: begin
        res_d = '0;
        res_d.present = pt_rd_q[0];
        if (pt_rd_q[0]) begin
          res_d.phys_out = {pt_rd_q[ENT_W-1:3], item_q.vaddr[PAGE_SHIFT-1:0]};
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_word_i;
    if (cmd_i.dir_alloc) begin
      slot_q <= nf_q[SLOT_W-1:0];
    end else if (cmd_i.slot_ld) begin
      slot_q <= dir_rd_q[SLOT_W-1:0];
    end
    res_q <= res_d;
    if (cmd_i.push) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // sweeps run the full table, so the counter wraps back to zero
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + IDX_W'(1);
      if (cmd_i.dir_alloc) nf_q <= nf_q + NF_W'(1);
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.action     = item_q.action;
  assign sts_o.dir_hit    = dir_rd_q[DIR_W-1];
  assign sts_o.pool_empty = (nf_q == NF_W'(TABLE_SLOTS));
  assign sts_o.cnt_last   = &cnt_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/ptab_checker.sv =====
// Port-level checks of the page table engine, bound to the top level.
`timescale 1ns / 1ps

module ptab_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ptab_pkg::out_word_t out_word_o
);
  import ptab_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == STS_DONE) ||
                    (out_word_o.status == STS_NO_TABLE) ||
                    (out_word_o.status == STS_POOL_EMPTY))
    else $error("undefined status code");

  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.present |-> out_word_o.status == STS_DONE)
    else $error("present page reported with failing status");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.present |-> out_word_o.phys_out == 32'd0)
    else $error("address returned for absent page");

  // one word at a time: the engine is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while the first is in flight");

endmodule

bind two_level_page_table_engine_core ptab_checker u_ptab_checker (.*);
